// ===== hdl/isb_pkg.sv =====
// Shared types, constants and the alphabet lookup for the signed integer to
// base string unit. No dependencies.
package isb_pkg;

    localparam int CELLS          = 64;   // digit cells, enough for base 2
    localparam int DIGIT_W        = 4;    // one digit of a base up to 16
    localparam int ALPHA_MAX      = 16;   // characters held by the alphabet regs
    localparam int MAX_DIGITS_DEF = 16;
    localparam int VALUE_W        = 64;
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 5;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd10;
    localparam logic [VALUE_W-1:0] CHARS_LOW_RST  = 64'd3978425819141910832;
    localparam logic [VALUE_W-1:0] CHARS_HIGH_RST = 64'd14648;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT,
        ST_ERR
    } isb_state_t;

    // Commands from the sequencer to every digit cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } isb_ctl_t;

    // Alphabet checker status.
    typedef struct packed {
        logic done;
        logic ok;
    } isb_chk_t;

    // Character k of the alphabet, character 0 in the low byte of the low word.
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [DIGIT_W-1:0] k,
        input logic [VALUE_W-1:0] chars_low,
        input logic [VALUE_W-1:0] chars_high
    );
        logic [VALUE_W-1:0] word;
        begin
            word = k[DIGIT_W-1] ? chars_high : chars_low;
            alpha_char = word[k[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
        end
    endfunction

endpackage

// ===== hdl/isb_cell.sv =====
// One digit cell of the skewed conversion array: doubles its digit and adds
// the incoming bit, modulo the base. Depends on isb_pkg.
module isb_cell
    import isb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  isb_ctl_t             ctl,
    input  logic [COUNT_W-1:0]   base,
    input  logic                 en_in,
    input  logic                 carry_in,
    input  logic [DIGIT_W-1:0]   shift_in,
    output logic [DIGIT_W-1:0]   digit,
    output logic                 en_out,
    output logic                 carry_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic               en_reg;
    logic               carry_reg;
    logic [COUNT_W-1:0] sum;
    logic               wrap;

    assign sum  = {digit_reg, carry_in};
    assign wrap = (sum >= base);

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.shift)
        begin
            digit_next = shift_in;
        end
        else if (en_in)
        begin
            digit_next = wrap ? DIGIT_W'(sum - base) : DIGIT_W'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    // Enable and carry travel one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            carry_reg <= 1'b0;
        end
        else
        begin
            en_reg    <= en_in && !ctl.clear;
            carry_reg <= en_in && !ctl.clear && wrap;
        end
    end

    assign digit     = digit_reg;
    assign en_out    = en_reg;
    assign carry_out = carry_reg;

endmodule

// ===== hdl/isb_check.sv =====
// Serial alphabet checker: one character per cycle against range rules and
// all later characters. Depends on isb_pkg.
module isb_check
    import isb_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [COUNT_W-1:0]   count,
    input  logic [VALUE_W-1:0]   chars_low,
    input  logic [VALUE_W-1:0]   chars_high,
    output isb_chk_t             status
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_DIGITS - 1);

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic          ok_reg;
    logic          ok_next;
    logic [CHAR_W-1:0] cur;
    logic          bad;

    always_comb
    begin
        cur = alpha_char(DIGIT_W'(idx_reg), chars_low, chars_high);
        bad = (cur <= CHAR_SPACE) || (cur == CHAR_PLUS) || (cur == CHAR_MINUS);
        for (int j = 0; j < ALPHA_MAX; j++)
        begin
            if ((j > int'(idx_reg)) && (j < int'(count)) &&
                (alpha_char(DIGIT_W'(j), chars_low, chars_high) == cur))
            begin
                bad = 1'b1;
            end
        end
        if (COUNT_W'(idx_reg) >= count)
        begin
            bad = 1'b0;
        end
    end

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        ok_next   = ok_reg;
        if (start)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            ok_next   = (count >= COUNT_W'(2)) && (count <= COUNT_W'(MAX_DIGITS));
        end
        else if (busy_reg)
        begin
            ok_next  = ok_reg && !bad;
            idx_next = idx_reg + IW'(1);
            if (idx_reg == IDX_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

// ===== hdl/signed_integer_to_base_string_unit.sv =====
// Top level of the signed integer to base string unit: config registers,
// sequencer, output register. Depends on isb_pkg, isb_cell, isb_check.
//
// Usage
//   Input channel in_valid/in_ready/value takes one signed 64-bit word.
//   Output channel out_valid/out_ready carries one character per word,
//   most significant first, a leading '-' for negatives, last on the final
//   character. A bad alphabet or the most negative value gives a single
//   word with out_char = 0, last = 1, error = 1. Config: cfg_we/cfg_index/
//   cfg_data; the user must write only while the unit is idle (not enforced).
// Timing
//   The magnitude is shifted MSB first into a 64-cell array of base-N digit
//   cells; carries move one cell per cycle. The digit scan then walks all
//   64 cells, one per cycle unless a stalled receiver holds the output,
//   skipping leading zeros without output. The alphabet check runs
//   alongside, one character per cycle. Error words also wait for the
//   end of conversion.
// Reset and stall
//   Reset restores base 10 with "0123456789" and drops any word in flight.
//   A stalled receiver holds the output register and stops the scan at the
//   next digit to output; the next value is taken as soon as the last word
//   of the previous one is loaded into the output register.
module signed_integer_to_base_string_unit
    import isb_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [VALUE_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHAR_W-1:0]         out_char,
    output logic                      last,
    output logic                      error
);

    localparam int CNT_W = $clog2(2 * CELLS - 1);
    localparam int REM_W = $clog2(CELLS + 1);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * CELLS - 2);
    localparam logic [CNT_W-1:0] FEED_END  = CNT_W'(CELLS);
    localparam logic [REM_W-1:0] REM_FULL  = REM_W'(CELLS);
    localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

    // Configuration
    logic [COUNT_W-1:0] count_reg;
    logic [VALUE_W-1:0] chars_low_reg;
    logic [VALUE_W-1:0] chars_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RST;
            chars_low_reg  <= CHARS_LOW_RST;
            chars_high_reg <= CHARS_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIGIT_COUNT: count_reg      <= cfg_data[COUNT_W-1:0];
                CFG_CHARS_LOW:   chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH:  chars_high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer state
    isb_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              started_reg, started_next;
    logic              neg_reg, neg_next;
    logic              minneg_reg, minneg_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              last_reg, last_next;
    logic              error_reg, error_next;

    logic              accept;
    logic              out_free;
    logic              feed;
    isb_ctl_t          ctl;
    isb_chk_t          chk;

    logic [DIGIT_W-1:0] dig [CELLS];
    logic               en_chain [CELLS];
    logic               carry_chain [CELLS];
    logic [DIGIT_W-1:0] top_digit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign feed      = (state_reg == ST_CONV) && (cnt_reg < FEED_END);
    assign top_digit = dig[CELLS-1];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        neg_next       = neg_reg;
        minneg_next    = minneg_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        ctl.clear      = 1'b0;
        ctl.shift      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next    = value[VALUE_W-1];
                    minneg_next = (value == {1'b1, {(VALUE_W-1){1'b0}}});
                    mag_next    = value[VALUE_W-1] ? (~$unsigned(value) + VALUE_W'(1))
                                                   : $unsigned(value);
                    cnt_next    = '0;
                    ctl.clear   = 1'b1;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (feed)
                begin
                    mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                end
                if (cnt_reg == CONV_LAST)
                begin
                    rem_next     = REM_FULL;
                    started_next = 1'b0;
                    if (!chk.ok || minneg_reg)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (neg_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    last_next      = 1'b0;
                    error_next     = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (!started_reg && (top_digit == '0) && (rem_reg != REM_ONE))
                begin
                    // leading zero, dropped
                    ctl.shift = 1'b1;
                    rem_next  = rem_reg - REM_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = alpha_char(top_digit, chars_low_reg, chars_high_reg);
                    last_next      = (rem_reg == REM_ONE);
                    error_next     = 1'b0;
                    started_next   = 1'b1;
                    ctl.shift      = 1'b1;
                    rem_next       = rem_reg - REM_W'(1);
                    if (rem_reg == REM_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NONE;
                    last_next      = 1'b1;
                    error_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        minneg_reg   <= minneg_next;
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

    // Digit cell array: cell 0 holds the least significant digit. During
    // conversion the enable and carry ripple up one cell per cycle; during
    // the scan digits move up toward the top cell, which is read out.
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            isb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .base      (count_reg),
                .en_in     (feed),
                .carry_in  (mag_reg[VALUE_W-1]),
                .shift_in  ({DIGIT_W{1'b0}}),
                .digit     (dig[k]),
                .en_out    (en_chain[k]),
                .carry_out (carry_chain[k])
            );
        end
        else
        begin : g_rest
            isb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .base      (count_reg),
                .en_in     (en_chain[k-1]),
                .carry_in  (carry_chain[k-1]),
                .shift_in  (dig[k-1]),
                .digit     (dig[k]),
                .en_out    (en_chain[k]),
                .carry_out (carry_chain[k])
            );
        end
    end

    isb_check #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .count      (count_reg),
        .chars_low  (chars_low_reg),
        .chars_high (chars_high_reg),
        .status     (chk)
    );

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    // Checks

    // alphabet verdict is ready before conversion ends
    a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && cnt_reg == CONV_LAST) |-> chk.done)
        else $error("alphabet check not finished at end of conversion");

    // with a valid base no carry leaves the top cell
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (en_chain[CELLS-1] && chk.done && chk.ok) |-> !carry_chain[CELLS-1])
        else $error("digit array overflow");

    // a new word restarts the alphabet check
    a_check_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !chk.done)
        else $error("alphabet check not restarted");

endmodule

// ===== sim/signed_integer_to_base_string_unit_tb.sv =====
// Self-checking bench for signed_integer_to_base_string_unit: drives values, rewrites
// the digit alphabet between phases and checks every character word against a predictor.
// Depends on isb_pkg and the unit's RTL.
module signed_integer_to_base_string_unit_tb;
    import isb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_MAX_DIGITS = MAX_DIGITS_DEF;
    localparam int SETTLE_CYCLES = 8;     // quiet cycles before touching config
    localparam int TAIL_CYCLES   = 256;   // quiet cycles after the final drain
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
    localparam int REPORT_MAX    = 10;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 24;

    // index 3 is decoded by nobody; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one character word as it leaves the unit
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } text_word_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the alphabet registers, spells each
    // accepted value into the words it must produce, and checks the words
    // coming out in order.
    // ------------------------------------------------------------------
    class base_text_scoreboard;
        logic [COUNT_W-1:0] digit_count;
        logic [VALUE_W-1:0] chars_lo;
        logic [VALUE_W-1:0] chars_hi;
        text_word_t         expected_text[$];
        int unsigned        mismatches;
        int unsigned        words_checked;
        int unsigned        values_noted;

        function new();
            digit_count   = COUNT_RST;
            chars_lo      = CHARS_LOW_RST;
            chars_hi      = CHARS_HIGH_RST;
            mismatches    = 0;
            words_checked = 0;
            values_noted  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
            case (idx)
                CFG_DIGIT_COUNT: digit_count = data[COUNT_W-1:0];
                CFG_CHARS_LOW:   chars_lo = data;
                CFG_CHARS_HIGH:  chars_hi = data;
                default: ;
            endcase
        endfunction

        function logic [CHAR_W-1:0] digit_char(int k);
            if (k < 8)
                return chars_lo[k*CHAR_W +: CHAR_W];
            return chars_hi[(k-8)*CHAR_W +: CHAR_W];
        endfunction

        // base in range, every used char printable, no sign chars, no repeats
        function bit alphabet_ok();
            int n;
            logic [CHAR_W-1:0] c;
            n = digit_count;
            if (n < 2 || n > TB_MAX_DIGITS)
                return 1'b0;
            for (int i = 0; i < n; i++) begin
                c = digit_char(i);
                if (c <= CHAR_SPACE || c == CHAR_PLUS || c == CHAR_MINUS)
                    return 1'b0;
                for (int j = i + 1; j < n; j++)
                    if (digit_char(j) == c)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void spell_value(logic signed [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] base;
            logic [DIGIT_W-1:0] digits[$];
            values_noted++;
            if (!alphabet_ok() || v == MOST_NEG) begin
                expected_text.push_back('{ch: CHAR_NONE, last: 1'b1, err: 1'b1});
                return;
            end
            base = VALUE_W'(digit_count);
            mag  = v[VALUE_W-1] ? (~v + 64'd1) : v;
            // zero still yields one digit
            do begin
                digits.push_front(DIGIT_W'(mag % base));
                mag = mag / base;
            end while (mag != 0);
            if (v[VALUE_W-1])
                expected_text.push_back('{ch: CHAR_MINUS, last: 1'b0, err: 1'b0});
            foreach (digits[i])
                expected_text.push_back('{ch: digit_char(digits[i]),
                                          last: (i == digits.size() - 1), err: 1'b0});
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic lst, logic err);
            text_word_t want;
            words_checked++;
            if (expected_text.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: word %0d with nothing pending: char %h last %b err %b",
                             $realtime, words_checked, ch, lst, err);
                return;
            end
            want = expected_text.pop_front();
            if (want.ch !== ch || want.last !== lst || want.err !== err) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: word %0d: want char %h last %b err %b, got %h %b %b",
                             $realtime, words_checked, want.ch, want.last, want.err,
                             ch, lst, err);
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [VALUE_W-1:0]        cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         out_char;
    logic                      last;
    logic                      error;

    signed_integer_to_base_string_unit #(
        .MAX_DIGITS(TB_MAX_DIGITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .error     (error)
    );

    base_text_scoreboard text_sb = new();

    int unsigned send_idle_pct = 0;   // chance per cycle the sender sits idle
    int unsigned recv_stall_pct = 0;  // chance per cycle the receiver stalls
    int unsigned hold_requests = 0;   // bumped by the sequence to ask for a long hold
    int unsigned alphabets_used = 1;  // reset alphabet counts as the first

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the unit hangs; far beyond the slowest legal run.
    initial
    begin
        #30ms;
        $display("signed_integer_to_base_string_unit_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per the current mode, plus a long hold-off
    // counted here whenever the sequence requests one. During the hold the
    // unit's output register fills and in_ready must drop.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold_served;
        int unsigned hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Output monitor: sampled at the edge, before the unit's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            text_sb.check_char(out_char, last, error);
    end

    // ------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------
    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default:       begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
    endtask

    // Offer one value and hold it until taken. Valid is only lowered when a
    // gap is actually inserted, so back-to-back words keep it high.
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        int unsigned gap;
        gap = 0;
        if (send_idle_pct != 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            // now and then a long gap so idle time lands mid-conversion too
            if ($urandom_range(15) == 0)
                gap += $urandom_range(250);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        text_sb.spell_value(v);
    endtask

    // Stop offering and wait for every pending word, then a few quiet cycles.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (text_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One config write per cycle; caller lowers cfg_we when done.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [VALUE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        text_sb.set_reg(idx, data);
    endtask

    task automatic set_alphabet(input logic [VALUE_W-1:0] count_word,
                                input logic [VALUE_W-1:0] lo,
                                input logic [VALUE_W-1:0] hi);
        quiesce();
        program_reg(CFG_DIGIT_COUNT, count_word);
        program_reg(CFG_CHARS_LOW, lo);
        program_reg(CFG_CHARS_HIGH, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
        alphabets_used++;
    endtask

    // Random alphabet: distinct printable chars for the used slots, junk in
    // the rest (must be ignored). Some phases get one defect planted.
    task automatic random_alphabet(input int unsigned base_req, input bit make_bad,
                                   output logic [VALUE_W-1:0] count_word,
                                   output logic [2*VALUE_W-1:0] chars);
        bit [255:0]        used;
        logic [CHAR_W-1:0] c;
        int unsigned       n;
        int unsigned       k;
        n     = (base_req != 0) ? base_req : $urandom_range(2, ALPHA_MAX);
        used  = '0;
        chars = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < n; i++)
        begin
            do c = CHAR_W'($urandom_range(33, 255));
            while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
            used[c] = 1'b1;
            chars[i*CHAR_W +: CHAR_W] = c;
        end
        if (make_bad)
        begin
            k = $urandom_range(n - 1);
            case ($urandom_range(4))
                0: n = $urandom_range(1);                 // too few chars
                1: n = $urandom_range(TB_MAX_DIGITS + 1, 31); // above the limit
                2: chars[k*CHAR_W +: CHAR_W] =            // repeat
                       chars[((k + 1) % n)*CHAR_W +: CHAR_W];
                3: chars[k*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(32));
                default: chars[k*CHAR_W +: CHAR_W] =
                             $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
            endcase
        end
        // junk in the upper bits of the count word; only the low bits count
        count_word = {$urandom, $urandom};
        count_word[COUNT_W-1:0] = COUNT_W'(n);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(6))
            0, 1: ;                                   // full width
            2: v = v >>> $urandom_range(63);          // varied magnitude
            3: v = v >>> $urandom_range(48, 63);      // short texts
            4:
            begin
                v = $urandom_range(2000);
                v = v - 1000;
            end
            5:
            begin
                v = 64'sd1 <<< $urandom_range(62);
                if ($urandom_range(1))
                    v = -v;
            end
            default:
                case ($urandom_range(4))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = MOST_NEG + 1;
                    3: v = '0;
                    default: v = -64'sd1;
                endcase
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [VALUE_W-1:0]   count_word;
        logic [2*VALUE_W-1:0] chars;
        idle_mode_t           mode;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset alphabet, base 10 ---
        set_idling(IDLE_NONE);
        send_value(64'sd0);
        send_value(64'sd7);
        send_value(-64'sd1);
        send_value(64'sd10);
        send_value(-64'sd123456789);
        send_value(MOST_POS);
        send_value(MOST_NEG);            // most negative: single error word
        send_value(MOST_NEG + 1);

        // base 2: longest text, 63 digits plus the sign
        set_alphabet(64'd2, 64'h3130, 64'h0);
        send_value(MOST_NEG + 1);
        send_value(MOST_POS);
        send_value(64'sd0);
        send_value(-64'sd2);

        // base 16 made only of bytes above 127
        set_alphabet(64'd16, 64'hF7F6_F5F4_F3F2_F1F0, 64'hFFFE_FDFC_FBFA_F9F8);
        send_value(-64'sd1);
        send_value(64'sh0123_4567_89AB_CDEF);
        send_value(MOST_POS);

        // bad counts; upper data bits must be dropped
        set_alphabet(64'hFFFF_FFFF_FFFF_FFE1, CHARS_LOW_RST, CHARS_HIGH_RST);  // 1
        send_value(64'sd5);
        set_alphabet(64'hFFFF_FFFF_FFFF_FFE0, CHARS_LOW_RST, CHARS_HIGH_RST);  // 0
        send_value(64'sd5);
        set_alphabet(64'hFFFF_FFFF_FFFF_FFF1, CHARS_LOW_RST, CHARS_HIGH_RST);  // 17
        send_value(64'sd5);
        set_alphabet(64'h1F, CHARS_LOW_RST, CHARS_HIGH_RST);                   // 31
        send_value(64'sd5);

        // bad characters inside a base-10 alphabet: space, plus, minus, repeat
        set_alphabet(64'd10, 64'h3736_3534_2032_3130, CHARS_HIGH_RST);
        send_value(64'sd5);
        set_alphabet(64'd10, 64'h2B36_3534_3332_3130, CHARS_HIGH_RST);
        send_value(64'sd5);
        set_alphabet(64'd10, CHARS_LOW_RST, 64'h2D38);
        send_value(64'sd5);
        set_alphabet(64'd10, 64'h3736_3234_3332_3130, CHARS_HIGH_RST);
        send_value(64'sd5);

        // '!' is the lowest legal char; junk past the count is ignored
        set_alphabet(64'd10, 64'h3736_3534_3332_3121, 64'h2D2B_2000_0000_3938);
        send_value(64'sd100);

        // write to the undecoded index: alphabet must stay as it is
        quiesce();
        program_reg(CFG_UNUSED, '1);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_value(-64'sd205);

        // --- random phases, rotating through the idling modes ---
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // base 2 and base 16 forced once each; every fifth phase is broken
            random_alphabet((ph == 0) ? 2 : (ph == 1) ? ALPHA_MAX : 0,
                            (ph % 5 == 3), count_word, chars);
            set_alphabet(count_word, chars[VALUE_W-1:0], chars[2*VALUE_W-1:VALUE_W]);
            mode = idle_mode_t'(ph % 4);
            set_idling(mode);
            // long receiver hold with the sender pushing back to back
            if (ph == 4 || ph == 8)
                hold_requests++;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // mid-phase: sender waits for a full drain, no config change
                if (ph == 6 && k == PHASE_ITEMS / 2)
                    quiesce();
                send_value(random_value());
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d values, %0d character words, %0d alphabet settings,",
                 text_sb.values_noted, text_sb.words_checked, alphabets_used);
        $display("bases 2 to 16, bad alphabets, sender and receiver stalls, long hold-off.");
        if (text_sb.mismatches == 0 && text_sb.pending() == 0)
        begin
            $display("signed_integer_to_base_string_unit_tb OK");
        end
        else
        begin
            $display("%0d mismatches, %0d words never seen",
                     text_sb.mismatches, text_sb.pending());
            $display("signed_integer_to_base_string_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/isb_pkg.sv
hdl/isb_cell.sv
hdl/isb_check.sv
hdl/signed_integer_to_base_string_unit.sv
sim/signed_integer_to_base_string_unit_tb.sv
